>>> rtl/double_hash_table_assert.svh
// Assertion macros used by the hash table top level.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dht_pkg.sv
// Types and constants of the double hashing hash table.
package dht_pkg;

  localparam int unsigned KeyWidth    = 31;
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned SlotWidth   = 8;
  localparam int unsigned SizeWidth   = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

>>> rtl/dht_stream_if.sv
// Valid/ready channel carrying a request or a response transaction.
interface dht_req_if;
  logic                               valid;
  logic                               ready;
  logic [dht_pkg::ActionWidth-1:0]    action;
  logic [dht_pkg::KeyWidth-1:0]       key;
  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface dht_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [dht_pkg::StatusWidth-1:0]    status;
  logic [dht_pkg::SlotWidth-1:0]      slot;
  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

>>> rtl/dht_ram.sv
// Generic single-port-write, registered-read RAM.
module dht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/dht_mod.sv
// Bit-serial restoring remainder unit: key mod divisor, one bit a cycle.
module dht_mod #(
  parameter int unsigned DivWidth = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dht_pkg::KeyWidth-1:0]  dividend,
  input  logic [DivWidth-1:0]           divisor,
  output logic                          busy,
  output logic [DivWidth-1:0]           remainder
);
  localparam int unsigned CntWidth = $clog2(dht_pkg::KeyWidth + 1);

  logic [dht_pkg::KeyWidth-1:0] shreg;
  logic [DivWidth-1:0]          dvs;
  logic [DivWidth:0]            rem;
  logic [CntWidth-1:0]          count;
  logic [DivWidth:0]            trial;
  logic [DivWidth:0]            sub;

  // Shift in the next dividend bit, subtract the divisor when it fits.
  always_comb begin
    trial = {rem[DivWidth-1:0], shreg[dht_pkg::KeyWidth-1]};
    sub   = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CntWidth'(dht_pkg::KeyWidth);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CntWidth'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= (trial >= {1'b0, dvs}) ? sub : trial;
    end
  end

  assign remainder = rem[DivWidth-1:0];
endmodule

>>> rtl/double_hash_table.sv
// Top level of the double hashing hash set.
//
//  channel  dir  payload               transaction
//  req      in   action[1:0] key[30:0]  req.valid & req.ready
//  rsp      out  status[1:0] slot[7:0]  rsp.valid & rsp.ready
//  cfg      in   table_size[8:0]        cfg_we
//
// After reset a clearing pass writes every slot mark to empty, one entry a
// cycle; no request is taken meanwhile.
// An item takes two remainder passes in one shared serial unit, the home pass
// and then the step pass, then per probe a mark/key memory read and a check;
// the response is valid once a probe ends the chain. Action 3 answers in the
// cycle after the request transaction.
// One item is in flight at a time; the response register holds the result
// while the sink stalls, and the next request is taken only once the
// response has been accepted.
`include "double_hash_table_assert.svh"

module double_hash_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dht_pkg::SizeWidth-1:0] cfg_wdata,
  dht_req_if.sink                    req,
  dht_rsp_if.source                  rsp
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = AW + 1;  // holds the size itself
  localparam int unsigned CW = (SW > dht_pkg::SizeWidth) ? SW : dht_pkg::SizeWidth;

  dht_pkg::state_t state, state_next;

  logic [dht_pkg::SizeWidth-1:0] table_size;
  logic [SW-1:0]  eff;             // effective size, latched per item
  logic [dht_pkg::KeyWidth-1:0] key;
  dht_pkg::action_t action;
  logic           second;          // second remainder pass started
  logic [AW-1:0]  idx;
  logic [SW-1:0]  step;
  logic [SW-1:0]  probes;
  logic [AW-1:0]  clr_addr;
  logic [CW-1:0]  size_wide;
  logic [SW-1:0]  size_sat;

  // Saturate the configured size to 2..TABLE_DEPTH.
  always_comb begin
    size_wide = CW'(table_size);
    if (size_wide < CW'(2)) begin
      size_sat = SW'(2);
    end else if (size_wide > CW'(TABLE_DEPTH)) begin
      size_sat = SW'(TABLE_DEPTH);
    end else begin
      size_sat = SW'(size_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= dht_pkg::SizeWidth'(256);
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // Shared remainder unit.
  logic           mod_start, mod_busy;
  logic [SW-1:0]  mod_div, mod_rem;

  dht_mod #(.DivWidth(SW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key),
    .divisor  (mod_div),
    .busy     (mod_busy),
    .remainder(mod_rem)
  );

  // Memories: marks and keys.
  logic                 mark_we, key_we;
  logic [AW-1:0]        mark_waddr;
  logic [1:0]           mark_wdata;
  logic [1:0]           mark_rdata;
  logic [dht_pkg::KeyWidth-1:0] key_rdata;

  dht_ram #(.Width(2), .Depth(TABLE_DEPTH)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(idx), .rdata(mark_rdata)
  );

  dht_ram #(.Width(dht_pkg::KeyWidth), .Depth(TABLE_DEPTH)) u_key (
    .clk(clk), .we(key_we), .waddr(idx), .wdata(key),
    .raddr(idx), .rdata(key_rdata)
  );

  // Probe decision on the data read for the current slot.
  logic hit, miss_end, last_probe;
  logic [SW:0] idx_sum;
  logic [AW-1:0] idx_adv;

  always_comb begin
    hit      = 1'b0;
    miss_end = 1'b0;
    if (action == dht_pkg::ACT_INSERT) begin
      hit = (mark_rdata != dht_pkg::MARK_USED);
    end else begin
      hit      = (mark_rdata == dht_pkg::MARK_USED) && (key_rdata == key);
      miss_end = (mark_rdata == dht_pkg::MARK_EMPTY);
    end
    last_probe = (probes == eff - SW'(1));
    idx_sum    = {2'b00, idx} + {1'b0, step};
    if (idx_sum >= {1'b0, eff}) begin
      idx_sum = idx_sum - {1'b0, eff};
    end
    idx_adv = idx_sum[AW-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dht_pkg::S_CLEAR: begin
        if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = dht_pkg::S_IDLE;
      end
      dht_pkg::S_IDLE: begin
        if (req.valid && !rsp.valid) begin
          state_next = (req.action == dht_pkg::ACT_NONE) ? dht_pkg::S_DONE
                                                          : dht_pkg::S_MOD;
        end
      end
      dht_pkg::S_MOD: begin
        if (!mod_busy && !mod_start && second) state_next = dht_pkg::S_READ;
      end
      dht_pkg::S_READ:  state_next = dht_pkg::S_CHECK;
      dht_pkg::S_CHECK: begin
        state_next = (hit || miss_end || last_probe) ? dht_pkg::S_DONE
                                                     : dht_pkg::S_READ;
      end
      dht_pkg::S_DONE:  state_next = dht_pkg::S_IDLE;
      default:          state_next = dht_pkg::S_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    req.ready  = 1'b0;
    mark_we    = 1'b0;
    key_we     = 1'b0;
    mark_waddr = idx;
    mark_wdata = dht_pkg::MARK_USED;
    case (state)
      dht_pkg::S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_addr;
        mark_wdata = dht_pkg::MARK_EMPTY;
      end
      dht_pkg::S_IDLE: req.ready = !rsp.valid;
      dht_pkg::S_CHECK: begin
        if (hit && action == dht_pkg::ACT_INSERT) begin
          mark_we = 1'b1;
          key_we  = 1'b1;
        end else if (hit && action == dht_pkg::ACT_REMOVE) begin
          mark_we    = 1'b1;
          mark_wdata = dht_pkg::MARK_DELETED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dht_pkg::S_CLEAR;
      clr_addr <= '0;
      rsp.valid <= 1'b0;
      mod_start <= 1'b0;
      second   <= 1'b0;
    end else begin
      state     <= state_next;
      // Start the home pass on a new request; after home = key mod S, start
      // the step pass with S-1.
      mod_start <= (state == dht_pkg::S_IDLE && req.valid && req.ready &&
                    req.action != dht_pkg::ACT_NONE) ||
                   (state == dht_pkg::S_MOD && !mod_busy && !mod_start && !second);
      if (state == dht_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (state == dht_pkg::S_IDLE && req.valid && req.ready &&
          req.action != dht_pkg::ACT_NONE) begin
        second    <= 1'b0;
      end
      if (state == dht_pkg::S_MOD && !mod_busy && !mod_start && !second) begin
        second    <= 1'b1;
      end
      if ((state == dht_pkg::S_CHECK && state_next == dht_pkg::S_DONE) ||
          (state == dht_pkg::S_IDLE && state_next == dht_pkg::S_DONE)) begin
        rsp.valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == dht_pkg::S_IDLE && req.valid && req.ready) begin
      key    <= req.key;
      action <= dht_pkg::action_t'(req.action);
      eff    <= size_sat;
      probes <= '0;
      rsp.status <= dht_pkg::ST_MISSING;
      rsp.slot   <= '0;
    end
    if (state == dht_pkg::S_MOD && !mod_busy && !mod_start) begin
      if (!second) begin
        idx <= mod_rem[AW-1:0];
      end else begin
        step <= (eff - SW'(1)) - mod_rem;
      end
    end
    if (state == dht_pkg::S_CHECK) begin
      probes <= probes + SW'(1);
      if (!hit) idx <= idx_adv;
      if (hit) begin
        rsp.status <= dht_pkg::ST_OK;
        rsp.slot   <= dht_pkg::SlotWidth'(idx);
      end else if (action == dht_pkg::ACT_INSERT) begin
        rsp.status <= dht_pkg::ST_FULL;
      end
    end
  end

  assign mod_div = second ? (eff - SW'(1)) : eff;

  `DHT_ASSERT_IMP(a_no_write_idle, clk, rst, state == dht_pkg::S_IDLE, !mark_we,
                  "mark write while idle")
  `DHT_ASSERT_NEXT(a_rsp_after_done, clk, rst,
                   state == dht_pkg::S_CHECK && state_next == dht_pkg::S_DONE,
                   rsp.valid, "done without response")
  `DHT_ASSERT_IMP(a_slot_zero, clk, rst, rsp.valid && rsp.status != dht_pkg::ST_OK,
                  rsp.slot == '0, "slot set on failure")
endmodule

>>> test/tb_top.sv
// Self-checking testbench for the double hashing hash set.
`timescale 1ns / 100ps

typedef struct packed {
  dht_pkg::status_t status;
  logic [7:0]       slot;
} lookup_result_t;

class hash_set_scoreboard;
  logic [30:0]     key_store [256];
  dht_pkg::mark_t  slot_mark [256];
  logic [8:0]      table_size;
  lookup_result_t  pending_results [$];
  int              errors;

  function new();
    foreach (slot_mark[i]) begin
      slot_mark[i] = dht_pkg::MARK_EMPTY;
      key_store[i] = '0;
    end
    table_size = 9'd256;
    errors = 0;
  endfunction

  // Saturate the configured size to 2..256.
  function int unsigned live_size();
    if (table_size < 2) return 2;
    if (table_size > 256) return 256;
    return 32'(table_size);
  endfunction

  // Walk the probe chain; return the slot found or -1.
  function int walk_chain(logic [30:0] key, bit for_insert);
    int unsigned s, idx, stride;
    s = live_size();
    idx = key % s;
    stride = (s - 1) - (key % (s - 1));
    for (int unsigned i = 0; i < s; i++) begin
      if (for_insert) begin
        if (slot_mark[idx] != dht_pkg::MARK_USED) return idx;
      end else begin
        if (slot_mark[idx] == dht_pkg::MARK_EMPTY) return -1;
        if (slot_mark[idx] == dht_pkg::MARK_USED && key_store[idx] == key) return idx;
      end
      idx += stride;
      if (idx >= s) idx -= s;
    end
    return -1;
  endfunction

  function void note_request(logic [1:0] act, logic [30:0] key);
    lookup_result_t r;
    int where;
    r.status = dht_pkg::ST_MISSING;
    r.slot   = '0;
    if (act == dht_pkg::ACT_INSERT) begin
      where = walk_chain(key, 1'b1);
      if (where >= 0) begin
        key_store[where] = key;
        slot_mark[where] = dht_pkg::MARK_USED;
        r.status = dht_pkg::ST_OK;
        r.slot = where[7:0];
      end else begin
        r.status = dht_pkg::ST_FULL;
      end
    end else if (act == dht_pkg::ACT_SEARCH || act == dht_pkg::ACT_REMOVE) begin
      where = walk_chain(key, 1'b0);
      if (where >= 0) begin
        if (act == dht_pkg::ACT_REMOVE) slot_mark[where] = dht_pkg::MARK_DELETED;
        r.status = dht_pkg::ST_OK;
        r.slot = where[7:0];
      end
    end
    pending_results.push_back(r);
  endfunction

  function void check_response(logic [1:0] status, logic [7:0] slot);
    lookup_result_t r;
    if (pending_results.size() == 0) begin
      $display("%0t: response with none outstanding: status %0d slot %0d",
               $time, status, slot);
      errors++;
      return;
    end
    r = pending_results.pop_front();
    if (status !== r.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, status);
      errors++;
    end
    if (slot !== r.slot) begin
      $display("%0t: slot mismatch: expected %0d actual %0d", $time, r.slot, slot);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int WatchdogLimit = 5000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [dht_pkg::SizeWidth-1:0] cfg_wdata;

  dht_req_if req ();
  dht_rsp_if rsp ();

  double_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  hash_set_scoreboard sb = new();

  bit quiet;        // no idling in the closing phase
  bit long_hold;    // ask the receiver for one long stall
  int idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitor: check responses, note requests, count idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.slot);
      if (req.valid && req.ready) sb.note_request(req.action, req.key);
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d transactions outstanding",
                 $time, sb.pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  // Offer one transaction; hold valid until taken, then maybe idle.
  task automatic send(logic [1:0] act, logic [30:0] key);
    req.valid  <= 1'b1;
    req.action <= act;
    req.key    <= key;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every outstanding result is back.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_size(logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.table_size = value;
  endtask

  // Mostly small keys so chains collide and hit; some keys near the top.
  function automatic logic [30:0] pick_key(int unsigned s);
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 9);
    if (r < 7) return 31'($urandom_range(0, 3 * s));
    if (r == 7) begin
      k = $urandom;
      return k[30:0];
    end
    return 31'h7FFF_FFFF - 31'($urandom_range(0, 3 * s));
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return dht_pkg::ACT_INSERT;
    if (r < 14) return dht_pkg::ACT_SEARCH;
    if (r < 19) return dht_pkg::ACT_REMOVE;
    return dht_pkg::ACT_NONE;
  endfunction

  logic [8:0] sizes [13] = '{9'd2, 9'd3, 9'd5, 9'd7, 9'd13, 9'd31, 9'd97,
                             9'd256, 9'd511, 9'd0, 9'd1, 9'd300, 9'd128};

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    req.valid  = 1'b0;
    req.action = dht_pkg::ACT_INSERT;
    req.key    = '0;
    quiet      = 0;
    long_hold  = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme keys at the reset size, every action.
    send(dht_pkg::ACT_INSERT, 31'd0);
    send(dht_pkg::ACT_INSERT, 31'h7FFF_FFFF);
    send(dht_pkg::ACT_SEARCH, 31'h7FFF_FFFF);
    send(dht_pkg::ACT_SEARCH, 31'd0);
    send(dht_pkg::ACT_REMOVE, 31'd0);
    send(dht_pkg::ACT_SEARCH, 31'd0);
    send(dht_pkg::ACT_REMOVE, 31'd12345);
    send(dht_pkg::ACT_NONE,   31'h5555_5555);
    send(dht_pkg::ACT_INSERT, 31'h7FFF_FFFF);   // duplicate goes in a new slot
    send(dht_pkg::ACT_REMOVE, 31'h7FFF_FFFF);
    send(dht_pkg::ACT_SEARCH, 31'h7FFF_FFFF);   // second copy still found
    drain();

    // Directed: below-range size saturates to 2; fill up, then reuse a deleted slot.
    write_size(9'd0);
    send(dht_pkg::ACT_INSERT, 31'd4);
    send(dht_pkg::ACT_INSERT, 31'd5);
    send(dht_pkg::ACT_INSERT, 31'd6);           // full
    send(dht_pkg::ACT_SEARCH, 31'd9);           // chain exhausted without an empty slot
    send(dht_pkg::ACT_REMOVE, 31'd4);
    send(dht_pkg::ACT_INSERT, 31'd8);           // lands on the deleted mark
    send(dht_pkg::ACT_SEARCH, 31'd5);
    drain();

    // Grow back: entries from the small table sit off their new chains.
    write_size(9'd511);
    send(dht_pkg::ACT_SEARCH, 31'd5);
    send(dht_pkg::ACT_SEARCH, 31'd0);
    send(dht_pkg::ACT_INSERT, 31'd255);
    drain();

    // Random phases over many sizes, extremes included.
    foreach (sizes[p]) begin
      int unsigned s;
      write_size(sizes[p]);
      s = sb.live_size();
      if (p == 4) long_hold = 1;
      if (p == 12) quiet = 1;
      repeat (115) send(pick_action(), pick_key(s));
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/dht_pkg.sv
rtl/dht_stream_if.sv
rtl/dht_ram.sv
rtl/dht_mod.sv
rtl/double_hash_table.sv
test/tb_top.sv
